/* hdl/wsc_pkg.sv */
// Package with widths, constants and the arctangent table of the steering controller.
package wsc_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;
    // Width of the CORDIC x and y words: 33-bit differences scaled by 2^20,
    // plus growth of the vectoring gain and the pre-rotation.
    localparam int XY_W  = 56;
    localparam int Z_W   = 28;
    localparam int CFG_W = 16;
    localparam int IDX_W = 3;

    localparam logic signed [Z_W-1:0] PI_Q24 = 28'sd52707179;
    localparam int PI_Q13     = 25736;
    localparam int TWO_PI_Q13 = 51472;
    localparam int STOP_MARGIN_Q8  = 128;
    localparam int DETECT_RANGE_Q8 = 1280;

    typedef enum logic [IDX_W-1:0] {
        REG_TURN_GAIN_NEAR   = 3'd0,
        REG_TURN_GAIN_FAR    = 3'd1,
        REG_SPEED_GAIN       = 3'd2,
        REG_SPEED_LIMIT      = 3'd3,
        REG_SPEED_LIMIT_SLOW = 3'd4,
        REG_TURN_LIMIT       = 3'd5,
        REG_TURN_LIMIT_SLOW  = 3'd6,
        REG_CURVE_THRESHOLD  = 3'd7
    } reg_idx_t;

    // Side data that travels with an item down the CORDIC chain.
    typedef struct packed {
        logic               zero_vec;
        logic signed [15:0] heading;
        logic signed [15:0] obstacle_distance;
        logic               reverse;
        logic               slow;
    } side_t;

    // One slot of the chain: valid flag, vector, angle and side data.
    typedef struct packed {
        logic                  vld;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        side_t                 side;
    } slot_t;

    function automatic logic signed [Z_W-1:0] atan_q24(input int i);
        logic signed [Z_W-1:0] r;
        begin
            unique case (i)
                0:  r = 28'sd13176795;
                1:  r = 28'sd7778716;
                2:  r = 28'sd4110060;
                3:  r = 28'sd2086331;
                4:  r = 28'sd1047214;
                5:  r = 28'sd524117;
                6:  r = 28'sd262123;
                7:  r = 28'sd131069;
                default: r = (i < ATAN_ENTRIES) ? Z_W'(28'sd1 <<< (24 - i)) : '0;
            endcase
            atan_q24 = r;
        end
    endfunction

endpackage

/* hdl/wsc_cordic_cell.sv */
// One CORDIC vectoring cell of the bearing chain, with its output register.
module wsc_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  wsc_pkg::slot_t  din,
    output wsc_pkg::slot_t  dout
);
    import wsc_pkg::*;

    slot_t slot_reg;
    slot_t slot_next;

    always_comb
    begin
        slot_next = din;
        if (din.y >= 0)
        begin
            slot_next.x = din.x + (din.y >>> STAGE);
            slot_next.y = din.y - (din.x >>> STAGE);
            slot_next.z = din.z + atan_q24(STAGE);
        end
        else
        begin
            slot_next.x = din.x - (din.y >>> STAGE);
            slot_next.y = din.y + (din.x >>> STAGE);
            slot_next.z = din.z - atan_q24(STAGE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slot_reg <= '0;
        else if (en)
            slot_reg <= slot_next;
    end

    assign dout = slot_reg;
endmodule

/* hdl/wsc_steer.sv */
// Heading error wrap, turn gain and clamp, and forward speed, over three registered stages.
module wsc_steer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  wsc_pkg::slot_t       din,
    input  logic [15:0]          turn_gain_near,
    input  logic [15:0]          turn_gain_far,
    input  logic [15:0]          speed_gain,
    input  logic [14:0]          speed_limit,
    input  logic [14:0]          speed_limit_slow,
    input  logic [14:0]          turn_limit,
    input  logic [14:0]          turn_limit_slow,
    input  logic [14:0]          curve_threshold,
    output logic                 vld,
    output logic signed [15:0]   forward_speed,
    output logic signed [15:0]   turn_rate
);
    import wsc_pkg::*;

    // Stage A: bearing, error, wrap, gain choice, speed product.
    logic signed [Z_W:0]  zr;
    logic signed [15:0]   bearing;
    logic signed [19:0]   err, a1, a3, e;
    logic        [19:0]   m1, m2, m3, me;
    logic signed [16:0]   fd;
    logic signed [33:0]   sp_prod;

    logic                 a_vld_reg;
    logic signed [19:0]   a_e_reg;
    logic        [15:0]   a_gain_reg;
    logic signed [33:0]   a_sp_reg;
    logic                 a_far_reg, a_rev_reg, a_slow_reg;
    logic                 b_vld_reg;

    always_comb
    begin
        zr      = ({din.z[Z_W-1], din.z} + (Z_W+1)'(1024)) >>> 11;
        bearing = din.side.zero_vec ? 16'sd0 : zr[15:0];
        err     = 20'(bearing) - 20'(din.side.heading)
                  + (din.side.reverse ? 20'sd25736 : 20'sd0);
        a1 = err + 20'sd51472;
        a3 = err - 20'sd51472;
        m1 = a1[19] ? 20'(-a1) : a1;
        m2 = err[19] ? 20'(-err) : err;
        m3 = a3[19] ? 20'(-a3) : a3;
        priority if (m1 < m2 && m1 < m3) e = a1;
        else if (m2 < m1 && m2 < m3)     e = err;
        else if (m3 < m1 && m3 < m2)     e = a3;
        else                             e = '0;
        me = e[19] ? 20'(-e) : e;
        fd = 17'(din.side.obstacle_distance) - 17'sd128;
        sp_prod = 34'(fd) * $signed({18'd0, speed_gain});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            vld       <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= din.vld;
            b_vld_reg <= a_vld_reg;
            vld       <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_e_reg    <= e;
            a_gain_reg <= (me < 20'(curve_threshold)) ? turn_gain_near : turn_gain_far;
            a_sp_reg   <= sp_prod;
            a_far_reg  <= (fd > 17'sd1280);
            a_rev_reg  <= din.side.reverse;
            a_slow_reg <= din.side.slow;
        end
    end

    // Stage B: turn product and clamps.
    logic signed [36:0] t_prod, t_sh;
    logic signed [33:0] v_sh;
    logic        [14:0] tlim, vmax;
    logic signed [15:0] turn_c, v_c;

    logic signed [15:0] b_turn_reg, b_v_reg;
    logic               b_rev_reg;

    always_comb
    begin
        t_prod = 37'(a_e_reg) * $signed({21'd0, a_gain_reg});
        t_sh   = (t_prod + 37'sd2048) >>> 12;
        tlim   = a_slow_reg ? turn_limit_slow : turn_limit;
        vmax   = a_slow_reg ? speed_limit_slow : speed_limit;
        if (t_sh > $signed({22'd0, tlim}))        turn_c = $signed({1'b0, tlim});
        else if (t_sh < -$signed({22'd0, tlim}))  turn_c = -$signed({1'b0, tlim});
        else                                      turn_c = t_sh[15:0];
        v_sh = (a_sp_reg + 34'sd128) >>> 8;
        if (a_far_reg || v_sh > $signed({19'd0, vmax})) v_c = $signed({1'b0, vmax});
        else if (v_sh < 0)                              v_c = '0;
        else                                            v_c = v_sh[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_turn_reg <= turn_c;
            b_v_reg    <= v_c;
            b_rev_reg  <= a_rev_reg;
        end
    end

    // Stage C: sharp-turn stop and reverse sign.
    logic [15:0] tabs;
    logic signed [15:0] v_f;

    always_comb
    begin
        tabs = b_turn_reg[15] ? 16'(-b_turn_reg) : b_turn_reg;
        v_f  = (tabs < {1'b0, curve_threshold}) ? b_v_reg : '0;
        if (b_rev_reg)
            v_f = -v_f;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            forward_speed <= v_f;
            turn_rate     <= b_turn_reg;
        end
    end
endmodule

/* hdl/waypoint_steering_controller_core.sv */
// Top level of the waypoint steering controller: config registers, CORDIC chain, steering stages.
// Path: input register, CORDIC cells, then steering stages A, B and C to the master side.
// Throughput: one request per cycle; the whole datapath is a chain of registered cells that
// advances whenever the output register is empty or being drained.
// Reset: rst_n is asynchronous and active low; it empties the pipeline and loads the
// configuration registers with their default gains, limits and threshold.
module waypoint_steering_controller_core #(
    parameter int CORDIC_STAGES = wsc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // Config write port.
    input  logic                      cfg_we,
    input  logic [wsc_pkg::IDX_W-1:0] cfg_index,
    input  logic [wsc_pkg::CFG_W-1:0] cfg_data,
    // Slave side.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // tdata from bit 0: robot_x[31:0], robot_y[63:32], robot_heading[79:64],
    // goal_x[111:80], goal_y[143:112], obstacle_distance[159:144], reverse[160],
    // slow[161], zero fill to 168 bits.
    input  logic [167:0]              s_tdata,
    // Master side.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // tdata from bit 0: forward_speed[15:0], turn_rate[31:16].
    output logic [31:0]               m_tdata
);
    import wsc_pkg::*;

    localparam int NCELL = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    // Configuration registers, written by index; unknown indexes never occur since all
    // eight codes map to a register.
    logic [15:0] turn_gain_near_reg, turn_gain_far_reg, speed_gain_reg;
    logic [14:0] speed_limit_reg, speed_limit_slow_reg;
    logic [14:0] turn_limit_reg, turn_limit_slow_reg, curve_threshold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_gain_near_reg   <= 16'd1229;
            turn_gain_far_reg    <= 16'd6144;
            speed_gain_reg       <= 16'd1229;
            speed_limit_reg      <= 15'd1024;
            speed_limit_slow_reg <= 15'd819;
            turn_limit_reg       <= 15'd3277;
            turn_limit_slow_reg  <= 15'd2048;
            curve_threshold_reg  <= 15'd4289;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_TURN_GAIN_NEAR:   turn_gain_near_reg   <= cfg_data;
                REG_TURN_GAIN_FAR:    turn_gain_far_reg    <= cfg_data;
                REG_SPEED_GAIN:       speed_gain_reg       <= cfg_data;
                REG_SPEED_LIMIT:      speed_limit_reg      <= cfg_data[14:0];
                REG_SPEED_LIMIT_SLOW: speed_limit_slow_reg <= cfg_data[14:0];
                REG_TURN_LIMIT:       turn_limit_reg       <= cfg_data[14:0];
                REG_TURN_LIMIT_SLOW:  turn_limit_slow_reg  <= cfg_data[14:0];
                REG_CURVE_THRESHOLD:  curve_threshold_reg  <= cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // The whole chain moves in lock step. It advances unless a finished result sits in
    // the output register and the downstream side holds it off.
    logic en;
    logic out_vld;
    assign en       = !out_vld || m_tready;
    assign s_tready = en;

    // Input stage: differences, scaling by 2^20, and pre-rotation by pi for dx < 0.
    logic signed [32:0] dx, dy;
    slot_t               head;

    always_comb
    begin
        dx = 33'($signed(s_tdata[111:80])) - 33'($signed(s_tdata[31:0]));
        dy = 33'($signed(s_tdata[143:112])) - 33'($signed(s_tdata[63:32]));
        head.vld = s_tvalid && s_tready;
        head.x   = XY_W'(dx) <<< 20;
        head.y   = XY_W'(dy) <<< 20;
        head.z   = '0;
        if (dx < 0)
        begin
            head.z = (dy >= 0) ? PI_Q24 : -PI_Q24;
            head.x = -head.x;
            head.y = -head.y;
        end
        head.side.zero_vec          = (dx == 0) && (dy == 0);
        head.side.heading           = $signed(s_tdata[79:64]);
        head.side.obstacle_distance = $signed(s_tdata[159:144]);
        head.side.reverse           = s_tdata[160];
        head.side.slow              = s_tdata[161];
    end

    slot_t in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_reg <= '0;
        else if (en)
            in_reg <= head;
    end

    // Row of CORDIC cells, each rotating by one arctangent step.
    slot_t chain [0:NCELL];
    assign chain[0] = in_reg;

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        wsc_cordic_cell #(.STAGE(g)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (en),
            .din  (chain[g]),
            .dout (chain[g+1])
        );
    end

    logic signed [15:0] fwd, turn;

    wsc_steer u_steer (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .din             (chain[NCELL]),
        .turn_gain_near  (turn_gain_near_reg),
        .turn_gain_far   (turn_gain_far_reg),
        .speed_gain      (speed_gain_reg),
        .speed_limit     (speed_limit_reg),
        .speed_limit_slow(speed_limit_slow_reg),
        .turn_limit      (turn_limit_reg),
        .turn_limit_slow (turn_limit_slow_reg),
        .curve_threshold (curve_threshold_reg),
        .vld             (out_vld),
        .forward_speed   (fwd),
        .turn_rate       (turn)
    );

    assign m_tvalid = out_vld;
    assign m_tdata  = {turn, fwd};
endmodule

/* hdl/wsc_checker.sv */
// Port-level checker for the steering controller, bound to the top level.
module wsc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [31:0]  m_tdata
);
    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // The slave side is ready whenever the output register is free.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("not ready with empty output");

    // Ready follows the downstream side while a result waits.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (s_tready == m_tready))
        else $error("ready does not track downstream stall");

    // The symmetric turn clamp never yields the most negative code.
    a_turn: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:16] != 16'h8000))
        else $error("turn rate out of range");
endmodule

bind waypoint_steering_controller_core wsc_checker u_wsc_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

/* dv/tb_top.sv */
// Self-checking testbench for the waypoint steering controller core.
module tb_top;
    import wsc_pkg::*;

    localparam int STAGES    = CORDIC_STAGES_DEF;
    localparam int LATENCY   = STAGES + 5;
    localparam int MAX_CYCLE = 600000;
    localparam longint PRESCALE = 64'sd1048576;

    typedef struct packed {
        logic               slow;
        logic               reverse;
        logic signed [15:0] obstacle;
        logic signed [31:0] goal_y;
        logic signed [31:0] goal_x;
        logic signed [15:0] heading;
        logic signed [31:0] robot_y;
        logic signed [31:0] robot_x;
    } pose_req_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [167:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;

    waypoint_steering_controller_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Shadow copy of the configuration registers, updated as they are written.
    logic [15:0] gain_near_q, gain_far_q, spd_gain_q;
    logic [14:0] spd_lim_q, spd_lim_slow_q, turn_lim_q, turn_lim_slow_q, curve_thr_q;

    // Arctangent table in Q.24, 2^-i steps.
    longint atan_tab [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                              262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                              1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

    pose_req_t   pose_q [$];   // Requests waiting to be offered.
    logic [31:0] cmd_q [$];    // Expected {turn_rate, forward_speed} per accepted request.

    int  errors;
    int  cycles;
    int  n_sent;
    int  n_recv;
    int  n_ties;
    int  n_sharp;
    int  rx_hold;        // Long receiver hold-off, counted down in the receiver process.
    int  tx_gap;
    bit  s_taken;        // Set at the rising edge when the current request was accepted.
    bit  sender_pause;   // Holds the sender quiet while set; this bench leaves it clear.
    bit  no_idle;        // Phase without any gaps on either side.

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Random gap: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        if (errors <= 30)
            $display("ERROR cycle %0d: %s got %0d expected %0d", cycles, what,
                     $signed(got), $signed(want));
    endtask

    // Computes the speed and turn commands for one pose request.
    function automatic logic [31:0] steer_cmd(input pose_req_t p);
        longint dx, dy, x, y, z, xs, ys, bearing, err, a1, a3, m1, m2, m3, e;
        longint gain, turn, lim, fd, vmax, v;
        int i;
        dx = longint'(p.goal_x) - longint'(p.robot_x);
        dy = longint'(p.goal_y) - longint'(p.robot_y);
        if (dx == 0 && dy == 0)
        begin
            bearing = 0;
        end
        else
        begin
            x = dx * PRESCALE;
            y = dy * PRESCALE;
            z = 0;
            // Vectors in the left half plane are rotated by pi first.
            if (x < 0)
            begin
                z = (y >= 0) ? longint'(PI_Q24) : -longint'(PI_Q24);
                x = -x;
                y = -y;
            end
            for (i = 0; i < STAGES && i < 24; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_tab[i];
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_tab[i];
                end
            end
            bearing = (z + 1024) >>> 11;
        end
        err = bearing - longint'(p.heading) + (p.reverse ? PI_Q13 : 0);
        a1 = err + TWO_PI_Q13;
        a3 = err - TWO_PI_Q13;
        m1 = mag(a1);
        m2 = mag(err);
        m3 = mag(a3);
        if (m1 < m2 && m1 < m3)
            e = a1;
        else if (m2 < m1 && m2 < m3)
            e = err;
        else if (m3 < m1 && m3 < m2)
            e = a3;
        else
            e = 0;
        gain = (mag(e) < longint'(curve_thr_q)) ? longint'(gain_near_q) : longint'(gain_far_q);
        turn = (e * gain + 2048) >>> 12;
        lim = p.slow ? longint'(turn_lim_slow_q) : longint'(turn_lim_q);
        if (turn > lim)
            turn = lim;
        if (turn < -lim)
            turn = -lim;
        vmax = p.slow ? longint'(spd_lim_slow_q) : longint'(spd_lim_q);
        fd = longint'(p.obstacle) - STOP_MARGIN_Q8;
        if (fd > DETECT_RANGE_Q8)
        begin
            v = vmax;
        end
        else
        begin
            v = (fd * longint'(spd_gain_q) + 128) >>> 8;
            if (v > vmax)
                v = vmax;
            if (v < 0)
                v = 0;
        end
        // A sharp turn stops forward motion.
        if (!(mag(turn) < longint'(curve_thr_q)))
            v = 0;
        if (p.reverse)
            v = -v;
        return {turn[15:0], v[15:0]};
    endfunction

    // Rising edge: count cycles, record accepted requests, check results.
    always @(posedge clk)
    begin
        logic [31:0] want;
        cycles++;
        if (cycles > MAX_CYCLE)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            if (rst_n && s_tvalid && s_tready)
            begin
                cmd_q.push_back(steer_cmd(pose_req_t'(s_tdata[161:0])));
                n_sent++;
                s_taken = 1'b1;
            end
            if (rst_n && m_tvalid && m_tready)
            begin
                n_recv++;
                if (cmd_q.size() == 0)
                begin
                    report("result with nothing pending, forward_speed", m_tdata, 32'd0);
                end
                else
                begin
                    want = cmd_q.pop_front();
                    if (m_tdata[15:0] != want[15:0])
                        report("forward_speed", {{16{m_tdata[15]}}, m_tdata[15:0]},
                               {{16{want[15]}}, want[15:0]});
                    if (m_tdata[31:16] != want[31:16])
                        report("turn_rate", {{16{m_tdata[31]}}, m_tdata[31:16]},
                               {{16{want[31]}}, want[31:16]});
                    if (want[31:16] == 16'd0)
                        n_ties++;
                    if (want[15:0] == 16'd0)
                        n_sharp++;
                end
            end
        end
    end

    // Sender: offers the next pose request at the falling edge, with random gaps.
    always @(negedge clk)
    begin
        if (!s_tvalid || s_taken)
        begin
            s_taken = 1'b0;
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pose_q.size() != 0 && !sender_pause && rst_n)
            begin
                s_tdata  <= {6'd0, pose_q.pop_front()};
                s_tvalid <= 1'b1;
                tx_gap = pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off before the default-gain phase.
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else if (no_idle)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 99) < 50 &&
                        !m_tready);
        end
    end

    // Writes one register and mirrors it in the shadow copy.
    task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_TURN_GAIN_NEAR:   gain_near_q     = val;
            REG_TURN_GAIN_FAR:    gain_far_q      = val;
            REG_SPEED_GAIN:       spd_gain_q      = val;
            REG_SPEED_LIMIT:      spd_lim_q       = val[14:0];
            REG_SPEED_LIMIT_SLOW: spd_lim_slow_q  = val[14:0];
            REG_TURN_LIMIT:       turn_lim_q      = val[14:0];
            REG_TURN_LIMIT_SLOW:  turn_lim_slow_q = val[14:0];
            default:              curve_thr_q     = val[14:0];
        endcase
    endtask

    task automatic write_all(input logic [15:0] v [8]);
        int i;
        for (i = 0; i < 8; i++)
            write_reg(reg_idx_t'(i), v[i]);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic pose_req_t make_pose(input int sx, input int sy, input int hd,
                                            input int gx, input int gy, input int obs,
                                            input bit rev, input bit slw);
        pose_req_t p;
        p.robot_x  = sx;
        p.robot_y  = sy;
        p.heading  = hd[15:0];
        p.goal_x   = gx;
        p.goal_y   = gy;
        p.obstacle = obs[15:0];
        p.reverse  = rev;
        p.slow     = slw;
        return p;
    endfunction

    // Random pose: a waypoint near the robot or far away in about equal shares, a few coincident.
    function automatic pose_req_t rand_pose();
        pose_req_t p;
        int shape;
        shape = $urandom_range(0, 99);
        p.robot_x = $urandom;
        p.robot_y = $urandom;
        if (shape < 45)
        begin
            p.goal_x = p.robot_x + $signed($urandom_range(0, 2097152)) - 1048576;
            p.goal_y = p.robot_y + $signed($urandom_range(0, 2097152)) - 1048576;
        end
        else if (shape < 93)
        begin
            p.goal_x = $urandom;
            p.goal_y = $urandom;
        end
        else
        begin
            p.goal_x = p.robot_x;
            p.goal_y = p.robot_y;
        end
        // Headings stay mostly in range; some use the whole 16-bit field.
        if ($urandom_range(0, 9) == 0)
            p.heading = 16'($urandom);
        else
            p.heading = 16'($signed($urandom_range(0, 2 * PI_Q13)) - PI_Q13);
        if ($urandom_range(0, 1))
            p.obstacle = 16'($urandom);
        else
            p.obstacle = 16'($urandom_range(0, 1700));
        p.reverse = 1'($urandom);
        p.slow    = 1'($urandom);
        return p;
    endfunction

    // Waits until every expected result is back, then lets the pipeline drain.
    task automatic drain();
        while (pose_q.size() != 0 || s_tvalid || cmd_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic run_phase(input int count, input bit quiet);
        int i;
        no_idle = quiet;
        for (i = 0; i < count; i++)
            pose_q.push_back(rand_pose());
        drain();
    endtask

    initial
    begin
        logic [15:0] regs [8];
        int phase;
        errors = 0; cycles = 0; n_sent = 0; n_recv = 0; n_ties = 0; n_sharp = 0;
        rx_hold = 0; tx_gap = 0; s_taken = 1'b0; no_idle = 1'b0; sender_pause = 1'b0;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b0;
        gain_near_q = 16'd1229; gain_far_q = 16'd6144; spd_gain_q = 16'd1229;
        spd_lim_q = 15'd1024; spd_lim_slow_q = 15'd819;
        turn_lim_q = 15'd3277; turn_lim_slow_q = 15'd2048; curve_thr_q = 15'd4289;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed requests under the reset configuration.
        pose_q.push_back(make_pose(0, 0, 0, 0, 0, 0, 0, 0));                 // coincident
        pose_q.push_back(make_pose(0, 0, PI_Q13, 0, 0, 1000, 0, 0));         // exact tie
        pose_q.push_back(make_pose(0, 0, -PI_Q13, 0, 0, 1000, 0, 1));        // exact tie
        pose_q.push_back(make_pose(0, 0, 0, 0, 0, 1000, 1, 0));              // tie via reverse
        pose_q.push_back(make_pose(32'h7fffffff, 32'h7fffffff, 0,
                                   32'h80000000, 32'h80000000, 32767, 0, 0));
        pose_q.push_back(make_pose(32'h80000000, 32'h80000000, 0,
                                   32'h7fffffff, 32'h7fffffff, -32768, 1, 1));
        pose_q.push_back(make_pose(32'h80000000, 0, 0, 32'h7fffffff, 0, 1408, 0, 0));
        pose_q.push_back(make_pose(0, 32'h7fffffff, 0, 0, 32'h80000000, 1409, 0, 1));
        pose_q.push_back(make_pose(0, 0, 32767, 65536, 0, 500, 0, 0));       // heading range
        pose_q.push_back(make_pose(0, 0, -32768, 65536, 0, 500, 1, 0));
        pose_q.push_back(make_pose(0, 0, 0, -65536, 1, 800, 0, 0));
        pose_q.push_back(make_pose(0, 0, 0, -65536, -1, 800, 0, 1));
        pose_q.push_back(make_pose(0, 0, 0, 65536, 65536, 128, 0, 0));       // at the stop margin
        pose_q.push_back(make_pose(0, 0, 0, 65536, 1000, 127, 0, 0));
        pose_q.push_back(make_pose(0, 0, 0, 65536, 1000, 129, 1, 1));
        pose_q.push_back(make_pose(0, 0, 25736, 0, -65536, 600, 1, 1));
        pose_q.push_back(make_pose(5, 7, -100, 5, 8, 2000, 0, 0));
        pose_q.push_back(make_pose(-1, -1, 100, 0, 0, -1, 1, 0));
        drain();

        // Default gains with a long receiver hold-off so the pipeline backs up.
        @(posedge clk);
        rx_hold = 300;
        run_phase(190, 1'b0);

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: regs = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                            16'd25736, 16'd25736, 16'd25736};
                1: regs = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
                2: regs = '{16'd4096, 16'd8192, 16'd256, 16'h7fff, 16'd100,
                            16'd25736, 16'd1, 16'h8000};
                default:
                begin
                    regs[0] = 16'($urandom); regs[1] = 16'($urandom);
                    regs[2] = 16'($urandom);
                    regs[3] = 16'($urandom); regs[4] = 16'($urandom);
                    regs[5] = 16'($urandom_range(0, 25736));
                    regs[6] = 16'($urandom_range(0, 25736));
                    regs[7] = 16'($urandom_range(0, 25736));
                end
            endcase
            write_all(regs);
            run_phase(190, phase == 2);
        end

        $display("Sent %0d pose requests over six register settings, %0d results back",
                 n_sent, n_recv);
        $display("Zero turn results %0d, zero speed results %0d", n_ties, n_sharp);
        if (errors == 0 && cmd_q.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/wsc_pkg.sv
hdl/wsc_cordic_cell.sv
hdl/wsc_steer.sv
hdl/waypoint_steering_controller_core.sv
hdl/wsc_checker.sv
dv/tb_top.sv
